[sv/bse_pkg.sv]
// Package of the boot serial extractor: word types, control encodings,
// the match key and the byte classification used by the core.
// No dependencies.
package bse_pkg;

  // Word carried by the input channel.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_word_t;

  // Word carried by the result channel.
  typedef struct packed {
    logic [7:0] serial_char;
    logic       serial_empty;
    logic       truncated;
    logic       last_char;
  } out_word_t;

  // Scan phase of the current data set.
  typedef enum logic [2:0] {
    PH_SEARCH  = 3'b001,
    PH_COLLECT = 3'b010,
    PH_DONE    = 3'b100
  } phase_e;

  // Control of the core: scanning input, reading the store, presenting a result.
  typedef enum logic [2:0] {
    ST_SCAN = 3'b001,
    ST_READ = 3'b010,
    ST_OUT  = 3'b100
  } ctrl_e;

  typedef struct packed {
    logic       term;  // ends the serial
    logic       sep;   // path separator, restarts the segment
    logic       keep;  // letter or digit
    logic [7:0] ch;    // upper-case form of a kept byte
  } byte_class_t;

  localparam logic [2:0] KeyLen    = 3'd6;
  localparam logic [7:0] CharC     = 8'h63;
  localparam logic [7:0] CharCr    = 8'h0d;
  localparam logic [7:0] CharLf    = 8'h0a;
  localparam logic [7:0] CharSemi  = 8'h3b;
  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharBslsh = 8'h5c;
  localparam logic [7:0] CharSlash = 8'h2f;
  localparam logic [7:0] CaseShift = 8'h20;

  // Bytes of the key "cdrom:".
  function automatic logic [7:0] key_byte(logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = 8'h63;
      3'd1: b = 8'h64;
      3'd2: b = 8'h72;
      3'd3: b = 8'h6f;
      3'd4: b = 8'h6d;
      3'd5: b = 8'h3a;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic byte_class_t classify(logic [7:0] b);
    byte_class_t c;
    c.term = (b inside {CharCr, CharLf, CharSemi, CharNul});
    c.sep  = (b == CharBslsh) || (b == CharSlash);
    c.keep = 1'b0;
    c.ch   = b;
    if (b inside {[8'h61:8'h7a]}) begin
      c.keep = 1'b1;
      c.ch   = b - CaseShift;
    end else if (b inside {[8'h41:8'h5a], [8'h30:8'h39]}) begin
      c.keep = 1'b1;
    end
    return c;
  endfunction

endpackage

[sv/bse_stream_if.sv]
// Valid/ready channel of the boot serial extractor, one word per handshake.
// The word type is given by the instantiating level, usually from bse_pkg.
interface bse_stream_if #(
  parameter type T = logic [7:0]
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/bse_serial_store.sv]
// Character store of the boot serial extractor: one write port and one read
// port with registered read data. No package dependency.
module bse_serial_store #(
  parameter int Depth = 16,
  parameter int Aw    = 4
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [Aw-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic          rd_en_i,
  input  logic [Aw-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[sv/boot_serial_extractor_core.sv]
// Boot serial extractor: scans a data set for "cdrom:", keeps the upper-cased
// letters and digits of the last path segment that follows, and returns them one
// result word per character. Input bytes are taken at one per cycle while
// scanning. When a run is due the input is held off while the store drains: each
// character is read from the store, then presented as a result until taken, an
// order set by the single read port of the store; an empty run skips the read.
// Depends on bse_pkg, bse_stream_if and bse_serial_store.
module boot_serial_extractor_core
  import bse_pkg::*;
#(
  parameter int MAX_SERIAL_CHARS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bse_stream_if.sink   in_i,
  bse_stream_if.source out_o
);

  localparam int Lw = $clog2(MAX_SERIAL_CHARS + 1);
  localparam int Aw = (MAX_SERIAL_CHARS > 1) ? $clog2(MAX_SERIAL_CHARS) : 1;
  localparam logic [Lw-1:0] MaxLen = Lw'(MAX_SERIAL_CHARS);

  ctrl_e         state_q, state_d;
  phase_e        phase_q, phase_d;
  logic [2:0]    match_q, match_d;
  logic [Lw-1:0] len_q, len_d;
  logic          ovf_q, ovf_d;
  logic          clr_pend_q, clr_pend_d;
  logic          empty_q, empty_d;
  logic [Aw-1:0] idx_q, idx_d;

  logic          in_fire, out_fire, emit, wr_en, rd_en, is_last;
  logic [2:0]    match_nx;
  logic [7:0]    rd_data;
  byte_class_t   cls;

  assign in_i.ready = (state_q == ST_SCAN);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_o.valid && out_o.ready;
  assign cls        = classify(in_i.data.data_byte);
  assign rd_en      = (state_q == ST_READ);
  assign is_last    = empty_q || ((Lw'(idx_q) + Lw'(1)) == len_q);

  always_comb begin
    if ((match_q < KeyLen) && (in_i.data.data_byte == key_byte(match_q))) begin
      match_nx = match_q + 3'd1;
    end else begin
      match_nx = (in_i.data.data_byte == CharC) ? 3'd1 : 3'd0;
    end
  end

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    match_d    = match_q;
    len_d      = len_q;
    ovf_d      = ovf_q;
    clr_pend_d = clr_pend_q;
    empty_d    = empty_q;
    idx_d      = idx_q;
    emit       = 1'b0;
    wr_en      = 1'b0;

    case (state_q)
      ST_SCAN: begin
        if (in_fire) begin
          case (phase_q)
            PH_SEARCH: begin
              if (match_nx == KeyLen) begin
                match_d = 3'd0;
                phase_d = PH_COLLECT;
                len_d   = '0;
                ovf_d   = 1'b0;
              end else begin
                match_d = match_nx;
              end
              emit = in_i.data.end_of_data;
            end
            PH_COLLECT: begin
              if (cls.term) begin
                emit    = 1'b1;
                phase_d = PH_DONE;
              end else begin
                if (cls.sep) begin
                  len_d = '0;
                  ovf_d = 1'b0;
                end else if (cls.keep) begin
                  if (len_q < MaxLen) begin
                    wr_en = 1'b1;
                    len_d = len_q + Lw'(1);
                  end else begin
                    ovf_d = 1'b1;
                  end
                end
                emit = in_i.data.end_of_data;
              end
            end
            default: ;
          endcase

          if (emit) begin
            // The set is cleared only once the run has been delivered.
            clr_pend_d = in_i.data.end_of_data;
            idx_d      = '0;
            empty_d    = (len_d == '0);
            state_d    = (len_d == '0) ? ST_OUT : ST_READ;
          end else if (in_i.data.end_of_data) begin
            phase_d = PH_SEARCH;
            match_d = 3'd0;
            len_d   = '0;
            ovf_d   = 1'b0;
          end
        end
      end
      ST_READ: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_fire) begin
          if (is_last) begin
            state_d = ST_SCAN;
            if (clr_pend_q) begin
              phase_d    = PH_SEARCH;
              match_d    = 3'd0;
              len_d      = '0;
              ovf_d      = 1'b0;
              clr_pend_d = 1'b0;
            end
          end else begin
            idx_d   = idx_q + Aw'(1);
            state_d = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_SCAN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_SCAN;
      phase_q    <= PH_SEARCH;
      match_q    <= 3'd0;
      len_q      <= '0;
      ovf_q      <= 1'b0;
      clr_pend_q <= 1'b0;
      empty_q    <= 1'b0;
      idx_q      <= '0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      match_q    <= match_d;
      len_q      <= len_d;
      ovf_q      <= ovf_d;
      clr_pend_q <= clr_pend_d;
      empty_q    <= empty_d;
      idx_q      <= idx_d;
    end
  end

  // Writes land while scanning and reads happen only after the input is held
  // off, so an entry is never read in the cycle it is written.
  bse_serial_store #(
    .Depth(MAX_SERIAL_CHARS),
    .Aw   (Aw)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(len_q[Aw-1:0]),
    .wr_data_i(cls.ch),
    .rd_en_i  (rd_en),
    .rd_addr_i(idx_q),
    .rd_data_o(rd_data)
  );

  assign out_o.valid             = (state_q == ST_OUT);
  assign out_o.data.serial_char  = empty_q ? 8'h00 : rd_data;
  assign out_o.data.serial_empty = empty_q;
  assign out_o.data.truncated    = empty_q ? 1'b0 : ovf_q;
  assign out_o.data.last_char    = is_last;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input taken while a result word is pending");

  a_nonempty_has_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.data.serial_empty) |-> (len_q != '0))
    else $error("character word presented with an empty store");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (len_q < MaxLen))
    else $error("store written beyond its depth");

  a_resume_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && out_o.data.last_char) |=> in_i.ready)
    else $error("input not resumed after the final word of a run");

endmodule

[verif/boot_serial_extractor_core_tb.sv]
// Self-checking testbench of boot_serial_extractor_core: random data sets with
// embedded "cdrom:" paths, checked word by word against an in-bench predictor.
// Depends on bse_pkg, bse_stream_if and the core with its store.
module boot_serial_extractor_core_tb;
  import bse_pkg::*;

  localparam int          SERIAL_CAP  = 16;
  localparam int          RANDOM_WORDS = 330;
  localparam logic [47:0] KEY_TEXT    = "cdrom:";

  logic clk = 1'b0;
  logic rst_n;

  bse_stream_if #(.T(in_word_t))  in_if ();
  bse_stream_if #(.T(out_word_t)) out_if ();

  boot_serial_extractor_core #(
    .MAX_SERIAL_CHARS(SERIAL_CAP)
  ) u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  always #4 clk = ~clk;

  in_word_t   byte_stream_q[$];
  logic [7:0] set_buf[$];
  out_word_t  serial_expect_q[$];
  int         stream_total;
  int         in_acc_cnt;
  int         err_cnt = 0;
  int         cyc_cnt;
  logic       tail_mode;
  logic       calm;
  int         send_gap;
  int         recv_gap;
  int         hold_left;
  logic       hold_done;

  // Extractor state as seen by the predictor.
  logic [2:0] key_pos;
  phase_e     scan_ph;
  logic [7:0] kept_chars[SERIAL_CAP];
  int         kept_len;
  logic       kept_ovf;

  // Calm stretches give the block runs with no idling on either side.
  assign calm = (cyc_cnt[7:6] == 2'b11);

  // ---------------------------------------------------------------- predictor
  function automatic void clear_extractor();
    key_pos  = 3'd0;
    scan_ph  = PH_SEARCH;
    kept_len = 0;
    kept_ovf = 1'b0;
  endfunction

  function automatic void emit_serial();
    out_word_t w;
    if (kept_len == 0) begin
      w.serial_char  = 8'h00;
      w.serial_empty = 1'b1;
      w.truncated    = 1'b0;
      w.last_char    = 1'b1;
      serial_expect_q.push_back(w);
      return;
    end
    for (int k = 0; k < kept_len; k++) begin
      w.serial_char  = kept_chars[k];
      w.serial_empty = 1'b0;
      w.truncated    = kept_ovf;
      w.last_char    = (k == kept_len - 1);
      serial_expect_q.push_back(w);
    end
  endfunction

  function automatic void keep_path_byte(logic [7:0] b);
    logic [7:0] ch;
    if (b == CharBslsh || b == CharSlash) begin
      kept_len = 0;
      kept_ovf = 1'b0;
      return;
    end
    if (b >= "a" && b <= "z") ch = b - CaseShift;
    else if ((b >= "A" && b <= "Z") || (b >= "0" && b <= "9")) ch = b;
    else return;
    if (kept_len < SERIAL_CAP) begin
      kept_chars[kept_len] = ch;
      kept_len++;
    end else begin
      kept_ovf = 1'b1;
    end
  endfunction

  function automatic void advance_extractor(in_word_t w);
    logic [7:0] b;
    b = w.data_byte;
    case (scan_ph)
      PH_SEARCH: begin
        if (key_pos < KeyLen && b == KEY_TEXT[47 - 8 * key_pos -: 8]) key_pos++;
        else key_pos = (b == CharC) ? 3'd1 : 3'd0;
        if (key_pos >= KeyLen) begin
          key_pos  = 3'd0;
          scan_ph  = PH_COLLECT;
          kept_len = 0;
          kept_ovf = 1'b0;
        end
        if (w.end_of_data) emit_serial();
      end
      PH_COLLECT: begin
        if (b == CharCr || b == CharLf || b == CharSemi || b == CharNul) begin
          emit_serial();
          scan_ph = PH_DONE;
        end else begin
          keep_path_byte(b);
          if (w.end_of_data) emit_serial();
        end
      end
      default: ;
    endcase
    if (w.end_of_data) clear_extractor();
  endfunction

  // ---------------------------------------------------------------- stimulus
  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) set_buf.push_back(s[i]);
  endtask

  // Moves the collected set to the stream; its final byte ends the data set.
  task automatic flush_set();
    in_word_t w;
    while (set_buf.size() != 0) begin
      w.data_byte   = set_buf.pop_front();
      w.end_of_data = (set_buf.size() == 0);
      byte_stream_q.push_back(w);
    end
  endtask

  function automatic logic [7:0] rand_path_char();
    logic [7:0] odd[9];
    odd = '{8'h2d, 8'h5f, 8'h2e, 8'h7e, 8'h20, 8'h40, 8'h5b, 8'h60, 8'h7b};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'h61 + 8'($urandom_range(0, 25));
      4, 5:       return 8'h41 + 8'($urandom_range(0, 25));
      6, 7:       return 8'h30 + 8'($urandom_range(0, 9));
      8:          return odd[$urandom_range(0, 8)];
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic build_random_set();
    int kind;
    int n;
    kind = $urandom_range(0, 9);
    n = $urandom_range(0, 4);
    repeat (n) set_buf.push_back(8'($urandom_range(0, 255)));
    if (kind < 7) begin
      if ($urandom_range(0, 3) == 0) push_text("cdr");
      push_text("cdrom:");
      repeat ($urandom_range(0, 3)) begin
        repeat ($urandom_range(0, 6)) set_buf.push_back(rand_path_char());
        set_buf.push_back(($urandom_range(0, 1) == 0) ? CharSlash : CharBslsh);
      end
      // A long final segment fills the store and drops the rest.
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 24) : $urandom_range(0, 10);
      repeat (n) set_buf.push_back(rand_path_char());
      case ($urandom_range(0, 4))
        0: set_buf.push_back(CharCr);
        1: set_buf.push_back(CharLf);
        2: set_buf.push_back(CharSemi);
        3: set_buf.push_back(CharNul);
        default: ;
      endcase
      repeat ($urandom_range(0, 3)) set_buf.push_back(8'($urandom_range(0, 255)));
    end else if (kind == 7) begin
      // Key broken at its fifth byte, two bytes short of a match.
      push_text("cdro");
      set_buf.push_back(8'h6e);
      repeat ($urandom_range(0, 5)) set_buf.push_back(rand_path_char());
    end else begin
      repeat ($urandom_range(1, 12)) set_buf.push_back(8'($urandom_range(0, 255)));
    end
    if (set_buf.size() == 0) set_buf.push_back(8'($urandom_range(0, 255)));
    flush_set();
  endtask

  // ---------------------------------------------------------------- sender
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
      send_gap    <= 0;
      tail_mode   <= 1'b0;
      cyc_cnt     <= 0;
    end else begin
      cyc_cnt <= cyc_cnt + 1;
      if (!in_if.valid || in_if.ready) begin
        if (send_gap != 0) begin
          send_gap    <= send_gap - 1;
          in_if.valid <= 1'b0;
        end else if (byte_stream_q.size() == 0) begin
          in_if.valid <= 1'b0;
        end else if (!tail_mode && !calm && $urandom_range(0, 7) == 0) begin
          send_gap    <= $urandom_range(0, 13);
          in_if.valid <= 1'b0;
        end else begin
          in_if.valid <= 1'b1;
          in_if.data  <= byte_stream_q.pop_front();
        end
      end
      tail_mode <= (byte_stream_q.size() < 40);
    end
  end

  // ---------------------------------------------------------------- receiver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      recv_gap     <= 0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (!hold_done && in_acc_cnt >= 150) begin
      // One long hold-off so that pending results back up into the input.
      hold_done    <= 1'b1;
      hold_left    <= 249;
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap     <= recv_gap - 1;
      out_if.ready <= 1'b0;
    end else if (!tail_mode && !calm && $urandom_range(0, 5) == 0) begin
      recv_gap     <= $urandom_range(0, 13);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk or negedge rst_n) begin
    out_word_t want;
    out_word_t got;
    if (!rst_n) begin
      in_acc_cnt <= 0;
      clear_extractor();
    end else begin
      if (in_if.valid && in_if.ready) begin
        advance_extractor(in_if.data);
        in_acc_cnt <= in_acc_cnt + 1;
      end
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        if (serial_expect_q.size() == 0) begin
          $error("serial word with nothing expected: char %0h empty %0b trunc %0b last %0b",
                 got.serial_char, got.serial_empty, got.truncated, got.last_char);
          err_cnt++;
        end else begin
          want = serial_expect_q.pop_front();
          if (got.serial_char !== want.serial_char) begin
            $error("serial_char: expected %0h, got %0h", want.serial_char, got.serial_char);
            err_cnt++;
          end
          if (got.serial_empty !== want.serial_empty) begin
            $error("serial_empty: expected %0b, got %0b", want.serial_empty, got.serial_empty);
            err_cnt++;
          end
          if (got.truncated !== want.truncated) begin
            $error("truncated: expected %0b, got %0b", want.truncated, got.truncated);
            err_cnt++;
          end
          if (got.last_char !== want.last_char) begin
            $error("last_char: expected %0b, got %0b", want.last_char, got.last_char);
            err_cnt++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    rst_n = 1'b0;

    // Partial match restarted by a repeated 'c', with the match on the final byte.
    push_text("ccdrom:");
    flush_set();
    // No match at all, top byte value.
    set_buf.push_back(8'hff);
    flush_set();
    // Lower case and digit kept, NUL ends the serial, trailing bytes ignored.
    push_text("cdrom:z9");
    set_buf.push_back(CharNul);
    set_buf.push_back(8'hff);
    flush_set();
    // Only separators and dropped bytes, terminator on the final byte.
    push_text("cdrom:/-\\;");
    flush_set();
    while (byte_stream_q.size() < RANDOM_WORDS) build_random_set();
    stream_total = byte_stream_q.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (in_acc_cnt != stream_total) @(negedge clk);
    while (serial_expect_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (serial_expect_q.size() != 0) begin
      $error("%0d serial words never arrived", serial_expect_q.size());
    end
    if (err_cnt == 0 && serial_expect_q.size() == 0) begin
      $display("boot_serial_extractor_core regression: pass");
    end else begin
      $display("boot_serial_extractor_core regression: fail");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("boot_serial_extractor_core regression: fail");
    $finish;
  end

endmodule
